[rtl/plvs_pkg.sv]
// ----------------------------------------------------------------------------
// plvs_pkg
// Shared types and constants for the per-link prediction vote smoother.
// ----------------------------------------------------------------------------
package plvs_pkg;

	// field widths fixed by the request format
	localparam int SLOT_W = 4;
	localparam int PROB_W = 16;
	localparam int LABEL_W = 2;
	localparam int VMIN_W = 5;
	localparam int CNT_W = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [PROB_W-1:0] prob_t;
	typedef logic [LABEL_W-1:0] label_t;
	typedef logic [VMIN_W-1:0] vmin_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// class labels
	localparam label_t LABEL_0 = 2'd0;
	localparam label_t LABEL_1 = 2'd1;
	localparam label_t LABEL_2 = 2'd2;

	// request kinds
	localparam logic KIND_CLASSIFY = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// configuration register indexes
	localparam cfg_idx_t REG_PROB_THRESHOLD = 2'd0;
	localparam cfg_idx_t REG_VOTE_MIN = 2'd1;

	// configuration reset values
	localparam prob_t PROB_THRESHOLD_RST = 16'd49152;
	localparam vmin_t VOTE_MIN_RST = 5'd4;

	// per-link label counts over the window
	typedef struct packed {
		cnt_t c0;
		cnt_t c1;
		cnt_t c2;
	} plvs_counts_t;

	localparam int COUNTS_W = 3 * CNT_W;

endpackage

[rtl/plvs_if.sv]
// ----------------------------------------------------------------------------
// plvs_in_if / plvs_out_if
// Valid/ready channels carrying smoother requests and results.
// ----------------------------------------------------------------------------
interface plvs_in_if;
	logic valid;
	logic ready;
	logic kind;
	plvs_pkg::slot_t link_slot;
	plvs_pkg::prob_t class0_prob;
	plvs_pkg::prob_t class1_prob;
	plvs_pkg::prob_t class2_prob;

	modport source (output valid, kind, link_slot, class0_prob, class1_prob, class2_prob,
		input ready);
	modport sink (input valid, kind, link_slot, class0_prob, class1_prob, class2_prob,
		output ready);
endinterface

interface plvs_out_if;
	logic valid;
	logic ready;
	plvs_pkg::slot_t slot_echo;
	plvs_pkg::label_t step_label;
	plvs_pkg::label_t smoothed_label;

	modport source (output valid, slot_echo, step_label, smoothed_label, input ready);
	modport sink (input valid, slot_echo, step_label, smoothed_label, output ready);
endinterface

[rtl/per_link_prediction_vote_smoother.sv]
// ----------------------------------------------------------------------------
// per_link_prediction_vote_smoother
// Per-link label ring and majority vote over three-class probabilities.
// ----------------------------------------------------------------------------
// Each request is a read-modify-write: the link's row (label ring, write
// position, kept class counts and vote) is read from a one-port synchronous
// memory when the request is taken, then modified and written back once the
// output register is free, and the next request is taken only once that
// write is done. The result sits in an output register, so a new request is
// taken while it waits. A link that was never written or was cleared reads
// as its fresh state through a per-link valid bit, so no clearing pass follows
// reset. Slots at or beyond LINKS change nothing and answer with labels 2.
module per_link_prediction_vote_smoother #(
	parameter int WINDOW = 10,
	parameter int LINKS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  plvs_pkg::cfg_idx_t   cfg_index,
	input  plvs_pkg::cfg_data_t  cfg_data,
	plvs_in_if.sink              in_ch,
	plvs_out_if.source           out_ch
);
	import plvs_pkg::*;

	localparam int LW = (LINKS > 1) ? $clog2(LINKS) : 1;
	localparam int RING_W = WINDOW * LABEL_W;
	localparam int ROW_W = LABEL_W + COUNTS_W + SLOT_W + RING_W;

	localparam plvs_counts_t COUNTS_RST = '{c0: '0, c1: '0, c2: CNT_W'(WINDOW)};
	localparam logic [ROW_W-1:0] ROW_RST = {LABEL_2, COUNTS_RST, SLOT_W'(0),
		{WINDOW{LABEL_2}}};

	// configuration registers
	prob_t threshold_q;
	vmin_t vote_min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= PROB_THRESHOLD_RST;
			vote_min_q <= VOTE_MIN_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_PROB_THRESHOLD: threshold_q <= cfg_data;
				REG_VOTE_MIN: vote_min_q <= cfg_data[VMIN_W-1:0];
				default: ;
			endcase
		end
	end

	// request handshake and row address
	logic busy_q;
	logic in_acc;
	logic advance;
	logic in_range;
	logic [LW-1:0] idx;
	logic [LW+SLOT_W-1:0] slot_ext;

	assign in_ch.ready = !busy_q;
	assign in_acc = in_ch.valid && in_ch.ready;
	assign slot_ext = {{LW{1'b0}}, in_ch.link_slot};
	assign idx = slot_ext[LW-1:0];
	assign in_range = 32'(in_ch.link_slot) < 32'(LINKS);

	// row memory and per-link valid bits
	logic [ROW_W-1:0] mem [LINKS];
	logic [LINKS-1:0] valid_q;
	logic [ROW_W-1:0] rd_s1;
	logic [ROW_W-1:0] row_nxt;

	// first stage request registers
	logic kind_s1;
	logic inr_s1;
	logic vld_s1;
	logic [LW-1:0] idx_s1;
	slot_t slot_s1;
	prob_t p0_s1;
	prob_t p1_s1;
	prob_t p2_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_s1 <= mem[idx];
			kind_s1 <= in_ch.kind;
			inr_s1 <= in_range;
			vld_s1 <= in_range ? valid_q[idx] : 1'b0;
			idx_s1 <= idx;
			slot_s1 <= in_ch.link_slot;
			p0_s1 <= in_ch.class0_prob;
			p1_s1 <= in_ch.class1_prob;
			p2_s1 <= in_ch.class2_prob;
		end
		if (advance && inr_s1 && kind_s1 == KIND_CLASSIFY) begin
			mem[idx_s1] <= row_nxt;
		end
	end

	// current row, fresh state when not yet valid
	logic [ROW_W-1:0] row_cur;
	logic [WINDOW-1:0][LABEL_W-1:0] ring_cur;
	logic [WINDOW-1:0][LABEL_W-1:0] ring_nxt;
	slot_t wslot_cur;
	slot_t wslot_nxt;
	plvs_counts_t counts_cur;
	plvs_counts_t counts_nxt;
	label_t voted_cur;
	label_t voted_nxt;
	label_t step_label;

	assign row_cur = vld_s1 ? rd_s1 : ROW_RST;
	assign {voted_cur, counts_cur, wslot_cur, ring_cur} = row_cur;
	assign row_nxt = {voted_nxt, counts_nxt, wslot_nxt, ring_nxt};

	plvs_update #(
		.WINDOW(WINDOW)
	) u_update (
		.ring(ring_cur),
		.wslot(wslot_cur),
		.counts(counts_cur),
		.voted(voted_cur),
		.p0(p0_s1),
		.p1(p1_s1),
		.p2(p2_s1),
		.threshold(threshold_q),
		.vote_min(vote_min_q),
		.ring_nxt(ring_nxt),
		.wslot_nxt(wslot_nxt),
		.counts_nxt(counts_nxt),
		.voted_nxt(voted_nxt),
		.step_label(step_label)
	);

	// write-back and result hand-off once the output register is free
	logic out_valid_q;
	slot_t out_slot_q;
	label_t out_step_q;
	label_t out_voted_q;
	logic do_update;

	assign advance = busy_q && (!out_valid_q || out_ch.ready);
	assign do_update = inr_s1 && kind_s1 == KIND_CLASSIFY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
			valid_q <= '0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (advance) begin
				busy_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				if (inr_s1) begin
					valid_q[idx_s1] <= (kind_s1 == KIND_CLASSIFY);
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_slot_q <= slot_s1;
			out_step_q <= do_update ? step_label : LABEL_2;
			out_voted_q <= do_update ? voted_nxt : LABEL_2;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.slot_echo = out_slot_q;
	assign out_ch.step_label = out_step_q;
	assign out_ch.smoothed_label = out_voted_q;

endmodule

[rtl/plvs_update.sv]
// ----------------------------------------------------------------------------
// plvs_update
// Step label choice, ring write, count upkeep and vote for one link row.
// ----------------------------------------------------------------------------
module plvs_update #(
	parameter int WINDOW = 10
) (
	input  logic [WINDOW-1:0][plvs_pkg::LABEL_W-1:0] ring,
	input  plvs_pkg::slot_t                           wslot,
	input  plvs_pkg::plvs_counts_t                    counts,
	input  plvs_pkg::label_t                          voted,
	input  plvs_pkg::prob_t                           p0,
	input  plvs_pkg::prob_t                           p1,
	input  plvs_pkg::prob_t                           p2,
	input  plvs_pkg::prob_t                           threshold,
	input  plvs_pkg::vmin_t                           vote_min,
	output logic [WINDOW-1:0][plvs_pkg::LABEL_W-1:0] ring_nxt,
	output plvs_pkg::slot_t                           wslot_nxt,
	output plvs_pkg::plvs_counts_t                    counts_nxt,
	output plvs_pkg::label_t                          voted_nxt,
	output plvs_pkg::label_t                          step_label
);
	import plvs_pkg::*;

	localparam int PW = $clog2(WINDOW);
	localparam logic [PW-1:0] POS_LAST = PW'(WINDOW - 1);

	logic [PW-1:0] pos;
	logic [PW-1:0] prev;
	label_t old_label;
	plvs_counts_t cnt;
	logic reach;

	// ring positions
	assign pos = wslot[PW-1:0];
	assign prev = (pos == '0) ? POS_LAST : pos - PW'(1);
	assign old_label = ring[pos];
	assign wslot_nxt = (pos == POS_LAST) ? '0 : SLOT_W'(pos) + SLOT_W'(1);

	// step label choice
	always_comb begin
		if (p0 > p1 && p0 > p2) begin
			step_label = LABEL_1;
		end else if (p1 >= threshold) begin
			step_label = LABEL_2;
		end else if (p2 >= threshold) begin
			step_label = LABEL_0;
		end else begin
			step_label = ring[prev];
		end
	end

	// write the new label into the ring
	always_comb begin
		ring_nxt = ring;
		ring_nxt[pos] = step_label;
	end

	// count upkeep: drop the overwritten label, add the new one
	always_comb begin
		cnt = counts;
		case (old_label)
			LABEL_0: cnt.c0 = cnt.c0 - CNT_W'(1);
			LABEL_1: cnt.c1 = cnt.c1 - CNT_W'(1);
			default: cnt.c2 = cnt.c2 - CNT_W'(1);
		endcase
		case (step_label)
			LABEL_0: cnt.c0 = cnt.c0 + CNT_W'(1);
			LABEL_1: cnt.c1 = cnt.c1 + CNT_W'(1);
			default: cnt.c2 = cnt.c2 + CNT_W'(1);
		endcase
		counts_nxt = cnt;
	end

	// majority vote once some class has enough hits
	assign reach = (cnt.c0 >= vote_min) || (cnt.c1 >= vote_min) || (cnt.c2 >= vote_min);

	always_comb begin
		if (!reach) begin
			voted_nxt = voted;
		end else if (cnt.c0 > cnt.c1 && cnt.c0 > cnt.c2) begin
			voted_nxt = LABEL_0;
		end else if (cnt.c1 > cnt.c2) begin
			voted_nxt = LABEL_1;
		end else begin
			voted_nxt = LABEL_2;
		end
	end

endmodule

[rtl/plvs_checker.sv]
// ----------------------------------------------------------------------------
// plvs_checker
// Port-level checks on the smoother's request and result channels.
// ----------------------------------------------------------------------------
module plvs_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input plvs_pkg::slot_t  slot_echo,
	input plvs_pkg::label_t step_label,
	input plvs_pkg::label_t smoothed_label
);
	import plvs_pkg::*;

	// a waiting result stays up until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	// one read-modify-write at a time: no request right after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while a row update is in flight");

	// a new result always follows row work on a request in progress
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a request in progress");

	// labels stay within the three classes
	a_label_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (step_label == LABEL_0 || step_label == LABEL_1 ||
			step_label == LABEL_2) && (smoothed_label == LABEL_0 ||
			smoothed_label == LABEL_1 || smoothed_label == LABEL_2))
		else $error("label code outside the three classes");

	// a stalled result keeps its slot
	a_slot_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(slot_echo))
		else $error("result slot changed while stalled");

endmodule

bind per_link_prediction_vote_smoother plvs_checker u_plvs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.slot_echo(out_ch.slot_echo),
	.step_label(out_ch.step_label),
	.smoothed_label(out_ch.smoothed_label)
);
